@@ src/ppid_pkg.sv @@
// ----------------------------------------------------------------------------
// ppid_pkg - shared types and constants of the positional PID block
// Word formats of both channels, register indexes, fixed-point constants
// and the saturation helper.
// ----------------------------------------------------------------------------
package ppid_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_PROP_GAIN   = 2'd0;
  localparam logic [1:0] REG_INTEG_GAIN  = 2'd1;
  localparam logic [1:0] REG_DERIV_GAIN  = 2'd2;
  localparam logic [1:0] REG_INTEG_LIMIT = 2'd3;

  // Milliseconds per second, used as multiplier and as divisor
  localparam int unsigned MS_PER_S = 1000;

  // Q16.16 products are shifted down by this many fraction bits
  localparam int unsigned FRAC_W = 16;

  // Serial divider: dividend width, quotient bits per cycle, cycle count
  localparam int unsigned DIV_W      = 64;
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_CYCLES = DIV_W / DIV_STEPS;
  localparam int unsigned CNT_W      = $clog2(DIV_CYCLES);

  // Widths of the signed terms and of their sum
  localparam int unsigned P_W   = 48;  // proportional term, |p| < 2^47
  localparam int unsigned D_W   = 59;  // derivative term,   |d| < 2^58
  localparam int unsigned SUM_W = 61;  // sum of all three terms

  typedef struct packed {
    logic               mode;
    logic signed [31:0] target;
    logic signed [31:0] measured;
    logic        [15:0] interval_ms;
  } pid_in_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic signed [31:0] deriv_term;
  } pid_out_t;

  // Saturate a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat_to_32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W-31){1'b0}}, {31{1'b1}}};
    lo = {{(SUM_W-31){1'b1}}, {31{1'b0}}};
    if (v > hi) begin
      sat_to_32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat_to_32 = 32'sh8000_0000;
    end else begin
      sat_to_32 = v[31:0];
    end
  endfunction

  // Magnitude of a signed 32-bit value; the most negative value gives 2^31
  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    abs32 = v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

@@ src/positional_pid_with_integral_clamp.sv @@
// ----------------------------------------------------------------------------
// positional_pid_with_integral_clamp - Q16.16 PID with anti-windup clamp
// One shared 32x32 multiplier and a four-bit-per-cycle divider run under a
// small sequencer to form the proportional, integral and derivative terms.
// ----------------------------------------------------------------------------
// Usage:
//   Write the gains and the integral limit on the cfg channel (index 0..3)
//   while the block is idle; cfg_ready_o is always high.
//   Present a word on in_word_i with in_valid_i; it is taken when in_stall_o
//   is low. A compute word (mode 0) returns drive and deriv_term; a clear
//   word (mode 1) zeroes the integral and returns two zeros.
//   Each word yields exactly one result word on out_word_o / out_valid_o,
//   taken at an edge where out_stall_i is low.
// Timing:
//   A compute word runs the integral pass (divide by 1000) and the
//   derivative pass (divide by the interval) of the serial divider only
//   when that term is active; a clear word skips both. in_stall_o stays
//   high while a word is in work; the next word is taken the cycle after the
//   result is loaded, even while that result still waits in the output
//   register. If the receiver stalls, the sequencer holds its finished
//   result until the output register frees up.
// Reset:
//   rst_ni clears gains, limit, integral, last error and the output valid.
module positional_pid_with_integral_clamp
  import ppid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // input word channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  pid_in_t     in_word_i,
  // result word channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output pid_out_t    out_word_o
);

  // Sequencer codes
  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_IMUL   = 5'd1;   // |err| * |ki|
  localparam logic [4:0] ST_IQLO   = 5'd2;   // low half of q * dt
  localparam logic [4:0] ST_IQHI   = 5'd3;   // high half of q * dt
  localparam logic [4:0] ST_IACC   = 5'd4;   // join halves, load divider
  localparam logic [4:0] ST_IDIV   = 5'd5;   // divide by 1000
  localparam logic [4:0] ST_ICLAMP = 5'd6;   // add and clamp integral
  localparam logic [4:0] ST_DMUL   = 5'd7;   // |diff| * |kd|
  localparam logic [4:0] ST_DQLO   = 5'd8;   // low half of q * 1000
  localparam logic [4:0] ST_DQHI   = 5'd9;   // high half of q * 1000
  localparam logic [4:0] ST_DACC   = 5'd10;  // join halves, load divider
  localparam logic [4:0] ST_DDIV   = 5'd11;  // divide by interval
  localparam logic [4:0] ST_DSAVE  = 5'd12;  // sign the derivative
  localparam logic [4:0] ST_PMUL   = 5'd13;  // |err| * |kp|
  localparam logic [4:0] ST_PSAVE  = 5'd14;  // sign the proportional term
  localparam logic [4:0] ST_SUM    = 5'd15;  // sum and saturate
  localparam logic [4:0] ST_OUT    = 5'd16;  // hand result to output reg

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_CYCLES - 1);

  logic [4:0] state_q, state_d;

  // configuration
  logic signed [31:0] kp_q, ki_q, kd_q;
  logic        [30:0] lim_q;

  // controller state
  logic signed [31:0] integ_q, integ_d;
  logic signed [31:0] prev_q;

  // per-word working registers
  logic signed [31:0]      err_q;
  logic        [15:0]      dt_q;
  logic                    neg_q;
  logic        [63:0]      prod_q;
  logic        [63:0]      acc_q;
  logic        [15:0]      qhi_q;
  logic        [DIV_W-1:0] quo_q, quo_d;
  logic        [15:0]      rem_q, rem_d;
  logic        [15:0]      den_q;
  logic        [CNT_W-1:0] cnt_q;
  logic signed [D_W-1:0]   d_q;
  logic signed [P_W-1:0]   p_q;
  pid_out_t                res_q;
  pid_out_t                out_q;
  logic                    out_valid_q;

  // shared multiplier operands
  logic [31:0] mul_a, mul_b;

  // combinational helpers
  logic               in_take;
  logic               out_free;
  logic signed [32:0] err_wide;
  logic signed [32:0] diff_wide;
  logic        [32:0] diff_abs;
  logic        [63:0] joined;
  logic signed [63:0] step_s;
  logic signed [63:0] integ_sum;
  logic signed [63:0] lim_pos;
  logic signed [SUM_W-1:0] term_sum;
  logic signed [SUM_W-1:0] d_wide;
  logic        [P_W-2:0] p_mag;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign err_wide  = {in_word_i.target[31], in_word_i.target}
                   - {in_word_i.measured[31], in_word_i.measured};
  assign diff_wide = {err_q[31], err_q} - {prev_q[31], prev_q};
  assign diff_abs  = diff_wide[32] ? (~diff_wide + 33'd1) : diff_wide;
  // high partial product lands 32 bits up
  assign joined    = acc_q + {prod_q[31:0], 32'd0};

  // integral update with clamp
  assign step_s    = neg_q ? -$signed(quo_q) : $signed(quo_q);
  assign integ_sum = 64'(integ_q) + step_s;
  assign lim_pos   = $signed({33'd0, lim_q});
  always_comb begin
    if (integ_sum > lim_pos) begin
      integ_d = $signed({1'b0, lim_q});
    end else if (integ_sum < -lim_pos) begin
      integ_d = -$signed({1'b0, lim_q});
    end else begin
      integ_d = integ_sum[31:0];
    end
  end

  assign p_mag    = prod_q[FRAC_W+P_W-2:FRAC_W];
  assign d_wide   = SUM_W'(d_q);
  assign term_sum = SUM_W'(p_q) + SUM_W'(integ_q) + d_wide;

  // Divider: four restoring steps per cycle; the remainder never
  // reaches the 16-bit divisor, so each compare is 17 bits wide.
  always_comb begin
    logic [16:0] trial;
    rem_d = rem_q;
    quo_d = quo_q;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {rem_d, quo_d[DIV_W-1]};
      quo_d = {quo_d[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d    = 16'(trial - {1'b0, den_q});
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial[15:0];
      end
    end
  end

  // Route operands to the shared multiplier
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state_q)
      ST_IMUL: begin
        mul_a = abs32(err_q);
        mul_b = abs32(ki_q);
      end
      ST_IQLO: begin
        mul_a = prod_q[FRAC_W+31:FRAC_W];
        mul_b = {16'd0, dt_q};
      end
      ST_IQHI: begin
        mul_a = {16'd0, qhi_q};
        mul_b = {16'd0, dt_q};
      end
      ST_DMUL: begin
        mul_a = diff_abs[31:0];
        mul_b = abs32(kd_q);
      end
      ST_DQLO: begin
        mul_a = prod_q[FRAC_W+31:FRAC_W];
        mul_b = 32'(MS_PER_S);
      end
      ST_DQHI: begin
        mul_a = {16'd0, qhi_q};
        mul_b = 32'(MS_PER_S);
      end
      ST_PMUL: begin
        mul_a = abs32(err_q);
        mul_b = abs32(kp_q);
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          state_d = in_word_i.mode ? ST_OUT : ST_IMUL;
        end
      end
      ST_IMUL: begin
        state_d = (err_q != 32'sd0 && ki_q != 32'sd0) ? ST_IQLO : ST_DMUL;
      end
      ST_IQLO:   state_d = ST_IQHI;
      ST_IQHI:   state_d = ST_IACC;
      ST_IACC:   state_d = ST_IDIV;
      ST_IDIV:   state_d = (cnt_q == DIV_LAST) ? ST_ICLAMP : ST_IDIV;
      ST_ICLAMP: state_d = ST_DMUL;
      ST_DMUL:   state_d = (kd_q != 32'sd0) ? ST_DQLO : ST_PMUL;
      ST_DQLO:   state_d = ST_DQHI;
      ST_DQHI:   state_d = ST_DACC;
      ST_DACC:   state_d = ST_DDIV;
      ST_DDIV:   state_d = (cnt_q == DIV_LAST) ? ST_DSAVE : ST_DDIV;
      ST_DSAVE:  state_d = ST_PMUL;
      ST_PMUL:   state_d = ST_PSAVE;
      ST_PSAVE:  state_d = ST_SUM;
      ST_SUM:    state_d = ST_OUT;
      ST_OUT:    state_d = out_free ? ST_IDLE : ST_OUT;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control state, configuration and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      lim_q       <= '0;
      integ_q     <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_PROP_GAIN:   kp_q  <= cfg_data_i;
          REG_INTEG_GAIN:  ki_q  <= cfg_data_i;
          REG_DERIV_GAIN:  kd_q  <= cfg_data_i;
          REG_INTEG_LIMIT: lim_q <= cfg_data_i[30:0];
          default:         kp_q  <= kp_q;
        endcase
      end
      // clear word drops the integral; clamp step writes the new one
      if (in_take && in_word_i.mode) begin
        integ_q <= '0;
      end else if (state_q == ST_ICLAMP) begin
        integ_q <= integ_d;
      end
      // last error advances only when the derivative is formed
      if (state_q == ST_DMUL && kd_q != 32'sd0) begin
        prev_q <= err_q;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          err_q <= sat_to_32(SUM_W'(err_wide));
          dt_q  <= in_word_i.interval_ms;
          res_q <= '0;
        end
      end
      ST_IMUL: neg_q <= err_q[31] ^ ki_q[31];
      ST_IQLO, ST_DQLO: qhi_q <= prod_q[63:48];
      ST_IQHI, ST_DQHI: acc_q <= prod_q;
      ST_IACC: begin
        quo_q <= joined;
        rem_q <= '0;
        den_q <= 16'(MS_PER_S);
        cnt_q <= '0;
      end
      ST_DACC: begin
        quo_q <= joined;
        rem_q <= '0;
        den_q <= (dt_q == 16'd0) ? 16'd1 : dt_q;
        cnt_q <= '0;
      end
      ST_IDIV, ST_DDIV: begin
        quo_q <= quo_d;
        rem_q <= rem_d;
        cnt_q <= cnt_q + CNT_W'(1);
      end
      ST_DMUL: begin
        neg_q <= diff_wide[32] ^ kd_q[31];
        d_q   <= '0;
      end
      ST_DSAVE: begin
        d_q <= neg_q ? -$signed(quo_q[D_W-1:0]) : $signed(quo_q[D_W-1:0]);
      end
      ST_PMUL: neg_q <= err_q[31] ^ kp_q[31];
      ST_PSAVE: begin
        p_q <= neg_q ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});
      end
      ST_SUM: begin
        res_q.drive      <= sat_to_32(term_sum);
        res_q.deriv_term <= sat_to_32(d_wide);
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
    if (state_q == ST_OUT && out_free) begin
      out_q <= res_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // an accepted word always keeps the input stalled in the cycle after it is taken
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a word was taken");

  // a new result only appears when the sequencer hands one over
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_OUT)
    else $error("result valid raised outside the hand-over step");

  // clamp keeps the integral inside the limit
  a_integ_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ICLAMP |=>
      ($signed({integ_q[31], integ_q}) <= $signed({2'b00, lim_q})) &&
      ($signed({integ_q[31], integ_q}) >= -$signed({2'b00, lim_q})))
    else $error("integral outside the clamp after update");

  // divider remainder stays below the divisor
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDIV || state_q == ST_DDIV) |-> rem_q < den_q)
    else $error("divider remainder not below divisor");

endmodule
